FILE: rtl/hfmp2_pkg.sv
package hfmp2_pkg;

	localparam int MAX_ORBITALS = 16;
	localparam int IDX_W        = $clog2(MAX_ORBITALS);
	localparam int CNT_W        = IDX_W + 1;
	localparam int VALUE_BITS   = 64;
	localparam int ADDR_W       = 4 * IDX_W;
	localparam int STORE_DEPTH  = MAX_ORBITALS ** 4;
	localparam int SMALL_AW     = IDX_W + 1;
	localparam int SMALL_DEPTH  = 2 * MAX_ORBITALS;
	localparam int ACC_W        = VALUE_BITS + 20;
	localparam int PROD_W       = 2 * VALUE_BITS;
	localparam int HALF_W       = VALUE_BITS / 2;
	localparam int CFG_IDX_W    = 2;

	typedef enum logic [2:0] {
		OP_DIAG     = 3'd0,
		OP_ENERGY   = 3'd1,
		OP_INTEGRAL = 3'd2,
		OP_COMPUTE  = 3'd3,
		OP_CLEAR    = 3'd4
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OCCUPIED = 2'd0,
		CFG_ORBITALS = 2'd1,
		CFG_NUCLEAR  = 2'd2
	} cfg_idx_t;

	function automatic logic signed [ACC_W-1:0] sext_acc(input logic [VALUE_BITS-1:0] v);
		return {{(ACC_W-VALUE_BITS){v[VALUE_BITS-1]}}, v};
	endfunction

	function automatic logic [VALUE_BITS-1:0] sat_acc(input logic signed [ACC_W-1:0] v);
		logic [ACC_W-VALUE_BITS:0] hi;
		hi = v[ACC_W-1:VALUE_BITS-1];
		if ((&hi) || (~|hi)) begin
			return v[VALUE_BITS-1:0];
		end else if (v[ACC_W-1]) begin
			return {1'b1, {(VALUE_BITS-1){1'b0}}};
		end else begin
			return {1'b0, {(VALUE_BITS-1){1'b1}}};
		end
	endfunction

	function automatic logic [VALUE_BITS-1:0] mag(input logic [VALUE_BITS-1:0] v);
		return v[VALUE_BITS-1] ? (~v + VALUE_BITS'(1)) : v;
	endfunction

	function automatic logic [ADDR_W-1:0] slot_addr(input logic [2:0] k,
		input logic [IDX_W-1:0] p, input logic [IDX_W-1:0] q,
		input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] s);
		logic [ADDR_W-1:0] a;
		case (k)
			3'd0: a = {p, q, r, s};
			3'd1: a = {r, s, p, q};
			3'd2: a = {p, s, r, q};
			3'd3: a = {r, q, p, s};
			3'd4: a = {q, p, s, r};
			3'd5: a = {s, r, q, p};
			3'd6: a = {q, r, s, p};
			default: a = {s, p, q, r};
		endcase
		return a;
	endfunction

endpackage

FILE: rtl/hf_mp2_energy_accumulator.sv
// Closed-shell Hartree-Fock and MP2 energy evaluator, signed Q24.40 throughout.
// Input words arrive on in_valid/in_ready with an op code: load a core diagonal
// entry, load an orbital energy, load a two-electron integral, compute, or clear.
// Registers are written on cfg_we with cfg_index and cfg_data; the user must
// write them only while idle, as the block does not enforce it. Diagonal and
// energy loads are written as they are accepted. An integral load writes its
// eight symmetric positions into the integral RAM, one per cycle. A compute
// request walks the stores through one read port at a time: a pass over the
// occupied orbitals, a pass over the occupied pairs, an energy fetch per
// occupied pair, and per MP2 term the shared 4-step multiplier and 128-step
// restoring divider when the denominator is nonzero. The result word is held
// in an output register until out_ready takes it. Loads are accepted while a
// result waits; a second compute finishes its walk and then holds until the
// output register is free. After reset, and after a clear request, a clearing
// pass zeros the integral RAM and the small store RAM with in_ready low.
module hf_mp2_energy_accumulator (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [2:0]                             op,
	input  logic [hfmp2_pkg::IDX_W-1:0]            index_p,
	input  logic [hfmp2_pkg::IDX_W-1:0]            index_q,
	input  logic [hfmp2_pkg::IDX_W-1:0]            index_r,
	input  logic [hfmp2_pkg::IDX_W-1:0]            index_s,
	input  logic signed [hfmp2_pkg::VALUE_BITS-1:0] value,
	input  logic                                   cfg_we,
	input  logic [hfmp2_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [hfmp2_pkg::VALUE_BITS-1:0]       cfg_data,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [hfmp2_pkg::VALUE_BITS-1:0] one_electron_term,
	output logic signed [hfmp2_pkg::VALUE_BITS-1:0] two_electron_term,
	output logic signed [hfmp2_pkg::VALUE_BITS-1:0] total_energy,
	output logic signed [hfmp2_pkg::VALUE_BITS-1:0] correlation_energy
);
	import hfmp2_pkg::*;

	typedef enum logic [9:0] {
		S_CLEAR = 10'b0000000001,
		S_IDLE  = 10'b0000000010,
		S_LOAD  = 10'b0000000100,
		S_ONE   = 10'b0000001000,
		S_TWO   = 10'b0000010000,
		S_EI    = 10'b0000100000,
		S_AB    = 10'b0001000000,
		S_MUL   = 10'b0010000000,
		S_DIV   = 10'b0100000000,
		S_FIN   = 10'b1000000000
	} state_t;

	state_t                   state_q;
	logic [2:0]               step_q;
	logic [CNT_W-1:0]         ci_q, cj_q, ca_q, cb_q;
	logic [CNT_W-1:0]         n_occ_q, n_orb_q;
	logic [CNT_W-1:0]         occ_q, orb_q;
	logic [VALUE_BITS-1:0]    nuc_q;
	logic [IDX_W-1:0]         ld_p_q, ld_q_q, ld_r_q, ld_s_q;
	logic [VALUE_BITS-1:0]    ld_v_q;
	logic [2:0]               ld_k_q;
	logic [ADDR_W-1:0]        clr_q;
	logic signed [ACC_W-1:0]  one_q, two_q, mp2_q;
	logic [VALUE_BITS-1:0]    ei_q, ej_q, ea_q, eb_q, x_q, y_q, f_q, d_q;
	logic                     neg_q;
	logic                     acc_pend_q;
	logic                     out_valid_q;
	logic [VALUE_BITS-1:0]    res_one_q, res_two_q, res_hf_q, res_mp2_q;

	logic                     in_fire;
	logic [CNT_W-1:0]         n_orb_c, n_occ_c;
	logic                     bwe;
	logic [ADDR_W-1:0]        bwaddr, braddr;
	logic [VALUE_BITS-1:0]    bwdata, brdata;
	logic                     swe;
	logic [SMALL_AW-1:0]      swaddr, sraddr;
	logic [VALUE_BITS-1:0]    swdata, srdata;
	logic                     mul_start, mul_done, div_start, div_done;
	logic [PROD_W-1:0]        product, quotient;
	logic [VALUE_BITS-1:0]    qsat;
	logic                     adv_term;
	logic                     fin_fire;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign n_orb_c  = (orb_q > CNT_W'(MAX_ORBITALS)) ? CNT_W'(MAX_ORBITALS) : orb_q;
	assign n_occ_c  = (occ_q > n_orb_c) ? n_orb_c : occ_q;

	always_comb begin
		bwe    = 1'b0;
		bwaddr = clr_q;
		bwdata = '0;
		if (state_q == S_CLEAR) begin
			bwe = 1'b1;
		end else if (state_q == S_LOAD) begin
			bwe    = 1'b1;
			bwaddr = slot_addr(ld_k_q, ld_p_q, ld_q_q, ld_r_q, ld_s_q);
			bwdata = ld_v_q;
		end
	end

	always_comb begin
		swe    = 1'b0;
		swaddr = clr_q[SMALL_AW-1:0];
		swdata = '0;
		if (state_q == S_CLEAR) begin
			swe = 1'b1;
		end else if (in_fire && (op_t'(op) == OP_DIAG || op_t'(op) == OP_ENERGY)) begin
			swe    = 1'b1;
			swaddr = {op_t'(op) == OP_ENERGY, index_p};
			swdata = value;
		end
	end

	always_comb begin
		braddr = '0;
		sraddr = '0;
		if (state_q == S_ONE) begin
			sraddr = {1'b0, ci_q[IDX_W-1:0]};
		end else if (state_q == S_TWO) begin
			if (step_q == 3'd0) begin
				braddr = {ci_q[IDX_W-1:0], cj_q[IDX_W-1:0], ci_q[IDX_W-1:0], cj_q[IDX_W-1:0]};
			end else begin
				braddr = {ci_q[IDX_W-1:0], cj_q[IDX_W-1:0], cj_q[IDX_W-1:0], ci_q[IDX_W-1:0]};
			end
		end else if (state_q == S_EI) begin
			sraddr = {1'b1, (step_q == 3'd0) ? ci_q[IDX_W-1:0] : cj_q[IDX_W-1:0]};
		end else if (state_q == S_AB) begin
			sraddr = {1'b1, (step_q == 3'd0) ? ca_q[IDX_W-1:0] : cb_q[IDX_W-1:0]};
			if (step_q == 3'd2) begin
				braddr = {ci_q[IDX_W-1:0], cj_q[IDX_W-1:0], ca_q[IDX_W-1:0], cb_q[IDX_W-1:0]};
			end else begin
				braddr = {ci_q[IDX_W-1:0], cj_q[IDX_W-1:0], cb_q[IDX_W-1:0], ca_q[IDX_W-1:0]};
			end
		end
	end

	hfmp2_ram #(.W(VALUE_BITS), .DEPTH(STORE_DEPTH)) u_integrals (
		.clk(clk), .we(bwe), .waddr(bwaddr), .wdata(bwdata), .raddr(braddr), .rdata(brdata)
	);

	hfmp2_ram #(.W(VALUE_BITS), .DEPTH(SMALL_DEPTH)) u_small (
		.clk(clk), .we(swe), .waddr(swaddr), .wdata(swdata), .raddr(sraddr), .rdata(srdata)
	);

	assign mul_start = (state_q == S_AB) && (step_q == 3'd6) && (d_q != '0);
	assign div_start = (state_q == S_MUL) && mul_done;

	hfmp2_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mag(x_q)), .b(mag(f_q)),
		.done(mul_done), .product(product)
	);

	hfmp2_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(product), .den(mag(d_q)),
		.done(div_done), .quotient(quotient)
	);

	always_comb begin
		if (neg_q) begin
			if ((|quotient[PROD_W-1:VALUE_BITS]) ||
				(quotient[VALUE_BITS-1] && (|quotient[VALUE_BITS-2:0]))) begin
				qsat = {1'b1, {(VALUE_BITS-1){1'b0}}};
			end else begin
				qsat = ~quotient[VALUE_BITS-1:0] + VALUE_BITS'(1);
			end
		end else begin
			if (|quotient[PROD_W-1:VALUE_BITS-1]) begin
				qsat = {1'b0, {(VALUE_BITS-1){1'b1}}};
			end else begin
				qsat = quotient[VALUE_BITS-1:0];
			end
		end
	end

	assign adv_term = ((state_q == S_AB) && (step_q == 3'd6) && (d_q == '0)) || acc_pend_q;
	assign fin_fire = (state_q == S_FIN) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= CNT_W'(1);
			orb_q <= CNT_W'(MAX_ORBITALS);
			nuc_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_OCCUPIED: occ_q <= cfg_data[CNT_W-1:0];
				CFG_ORBITALS: orb_q <= cfg_data[CNT_W-1:0];
				CFG_NUCLEAR:  nuc_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			step_q      <= '0;
			clr_q       <= '0;
			ld_k_q      <= '0;
			ci_q        <= '0;
			cj_q        <= '0;
			ca_q        <= '0;
			cb_q        <= '0;
			n_occ_q     <= '0;
			n_orb_q     <= '0;
			acc_pend_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			acc_pend_q <= 1'b0;
			if (fin_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (&clr_q) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_fire) begin
						step_q <= '0;
						case (op_t'(op))
							OP_INTEGRAL: begin
								ld_k_q  <= '0;
								state_q <= S_LOAD;
							end
							OP_COMPUTE: begin
								n_orb_q <= n_orb_c;
								n_occ_q <= n_occ_c;
								ci_q    <= '0;
								cj_q    <= '0;
								state_q <= S_ONE;
							end
							OP_CLEAR: begin
								clr_q   <= '0;
								state_q <= S_CLEAR;
							end
							default: ;
						endcase
					end
				end
				S_LOAD: begin
					ld_k_q <= ld_k_q + 3'd1;
					if (&ld_k_q) begin
						state_q <= S_IDLE;
					end
				end
				S_ONE: begin
					if (step_q == 3'd0) begin
						if (ci_q == n_occ_q) begin
							ci_q    <= '0;
							cj_q    <= '0;
							state_q <= S_TWO;
						end else begin
							step_q <= 3'd1;
						end
					end else begin
						ci_q   <= ci_q + CNT_W'(1);
						step_q <= 3'd0;
					end
				end
				S_TWO: begin
					if (step_q == 3'd0) begin
						if (ci_q == n_occ_q) begin
							ci_q    <= '0;
							cj_q    <= '0;
							state_q <= S_EI;
						end else begin
							step_q <= 3'd1;
						end
					end else if (step_q == 3'd1) begin
						step_q <= 3'd2;
					end else begin
						step_q <= 3'd0;
						if (cj_q + CNT_W'(1) == n_occ_q) begin
							cj_q <= '0;
							ci_q <= ci_q + CNT_W'(1);
						end else begin
							cj_q <= cj_q + CNT_W'(1);
						end
					end
				end
				S_EI: begin
					if (step_q == 3'd0) begin
						if (ci_q == n_occ_q || n_occ_q == n_orb_q) begin
							state_q <= S_FIN;
						end else begin
							step_q <= 3'd1;
						end
					end else if (step_q == 3'd1) begin
						step_q <= 3'd2;
					end else begin
						ca_q    <= n_occ_q;
						cb_q    <= n_occ_q;
						step_q  <= 3'd0;
						state_q <= S_AB;
					end
				end
				S_AB: begin
					if (step_q == 3'd6) begin
						if (d_q != '0) begin
							state_q <= S_MUL;
						end
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				S_MUL: begin
					if (mul_done) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						acc_pend_q <= 1'b1;
					end
				end
				S_FIN: begin
					if (fin_fire) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (adv_term) begin
				step_q  <= '0;
				state_q <= S_AB;
				if (cb_q + CNT_W'(1) == n_orb_q) begin
					cb_q <= n_occ_q;
					if (ca_q + CNT_W'(1) == n_orb_q) begin
						ca_q    <= n_occ_q;
						state_q <= S_EI;
						if (cj_q + CNT_W'(1) == n_occ_q) begin
							cj_q <= '0;
							ci_q <= ci_q + CNT_W'(1);
						end else begin
							cj_q <= cj_q + CNT_W'(1);
						end
					end else begin
						ca_q <= ca_q + CNT_W'(1);
					end
				end else begin
					cb_q <= cb_q + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			ld_p_q <= index_p;
			ld_q_q <= index_q;
			ld_r_q <= index_r;
			ld_s_q <= index_s;
			ld_v_q <= value;
			one_q  <= '0;
			two_q  <= '0;
			mp2_q  <= '0;
		end
		if (state_q == S_ONE) begin
			if (step_q == 3'd0 && ci_q == n_occ_q) begin
				one_q <= one_q <<< 1;
			end else if (step_q == 3'd1) begin
				one_q <= one_q + sext_acc(srdata);
			end
		end
		if (state_q == S_TWO) begin
			if (step_q == 3'd1) begin
				two_q <= two_q + (sext_acc(brdata) <<< 1);
			end else if (step_q == 3'd2) begin
				two_q <= two_q - sext_acc(brdata);
			end
		end
		if (state_q == S_EI) begin
			if (step_q == 3'd1) begin
				ei_q <= srdata;
			end else if (step_q == 3'd2) begin
				ej_q <= srdata;
			end
		end
		if (state_q == S_AB) begin
			case (step_q)
				3'd1: ea_q <= srdata;
				3'd2: eb_q <= srdata;
				3'd3: x_q  <= brdata;
				3'd4: y_q  <= brdata;
				3'd5: begin
					f_q <= sat_acc((sext_acc(x_q) <<< 1) - sext_acc(y_q));
					d_q <= sat_acc(sext_acc(ei_q) + sext_acc(ej_q) - sext_acc(ea_q)
						- sext_acc(eb_q));
				end
				3'd6: neg_q <= x_q[VALUE_BITS-1] ^ f_q[VALUE_BITS-1] ^ d_q[VALUE_BITS-1];
				default: ;
			endcase
		end
		if (acc_pend_q) begin
			mp2_q <= mp2_q + sext_acc(qsat);
		end
		if (fin_fire) begin
			res_one_q <= sat_acc(one_q);
			res_two_q <= sat_acc(two_q);
			res_hf_q  <= sat_acc(sext_acc(nuc_q) + one_q + two_q);
			res_mp2_q <= sat_acc(mp2_q);
		end
	end

	assign out_valid          = out_valid_q;
	assign one_electron_term  = res_one_q;
	assign two_electron_term  = res_two_q;
	assign total_energy       = res_hf_q;
	assign correlation_energy = res_mp2_q;
endmodule

FILE: rtl/hfmp2_ram.sv
module hfmp2_ram #(
	parameter int W     = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);
	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: rtl/hfmp2_mul.sv
module hfmp2_mul (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [hfmp2_pkg::VALUE_BITS-1:0]  a,
	input  logic [hfmp2_pkg::VALUE_BITS-1:0]  b,
	output logic                              done,
	output logic [hfmp2_pkg::PROD_W-1:0]      product
);
	import hfmp2_pkg::*;

	logic                busy_q;
	logic [2:0]          k_q;
	logic [VALUE_BITS-1:0] p_s1;
	logic [1:0]          pk_s1;
	logic                pv_s1;
	logic [PROD_W-1:0]   acc_q;
	logic                done_q;
	logic [HALF_W-1:0]   a_half;
	logic [HALF_W-1:0]   b_half;
	logic [PROD_W-1:0]   p_shift;

	assign a_half = k_q[1] ? a[VALUE_BITS-1:HALF_W] : a[HALF_W-1:0];
	assign b_half = k_q[0] ? b[VALUE_BITS-1:HALF_W] : b[HALF_W-1:0];

	always_comb begin
		case (pk_s1)
			2'd0:    p_shift = {{VALUE_BITS{1'b0}}, p_s1};
			2'd3:    p_shift = {p_s1, {VALUE_BITS{1'b0}}};
			default: p_shift = {{HALF_W{1'b0}}, p_s1, {HALF_W{1'b0}}};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q    <= '0;
			pv_s1  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				k_q    <= '0;
				pv_s1  <= 1'b0;
			end else if (busy_q) begin
				pv_s1 <= (k_q < 3'd4);
				k_q   <= k_q + 3'd1;
				if (pv_s1 && pk_s1 == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					pv_s1  <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
		end else if (busy_q) begin
			p_s1  <= a_half * b_half;
			pk_s1 <= k_q[1:0];
			if (pv_s1) begin
				acc_q <= acc_q + p_shift;
			end
		end
	end

	assign done    = done_q;
	assign product = acc_q;
endmodule

FILE: rtl/hfmp2_div.sv
module hfmp2_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [hfmp2_pkg::PROD_W-1:0]      num,
	input  logic [hfmp2_pkg::VALUE_BITS-1:0]  den,
	output logic                              done,
	output logic [hfmp2_pkg::PROD_W-1:0]      quotient
);
	import hfmp2_pkg::*;

	logic                  busy_q;
	logic [7:0]            cnt_q;
	logic [PROD_W-1:0]     nq_q;
	logic [VALUE_BITS:0]   rem_q;
	logic [VALUE_BITS-1:0] den_q;
	logic                  done_q;
	logic [VALUE_BITS:0]   rem_sh;
	logic                  fits;

	assign rem_sh = {rem_q[VALUE_BITS-1:0], nq_q[PROD_W-1]};
	assign fits   = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 8'd1;
				if (cnt_q == 8'(PROD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			nq_q  <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			nq_q  <= {nq_q[PROD_W-2:0], fits};
			rem_q <= fits ? (rem_sh - {1'b0, den_q}) : rem_sh;
		end
	end

	assign done     = done_q;
	assign quotient = nq_q;
endmodule

FILE: rtl/hfmp2_checker.sv
module hfmp2_checker (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   in_valid,
	input logic                                   in_ready,
	input logic [2:0]                             op,
	input logic                                   out_valid,
	input logic                                   out_ready,
	input logic signed [hfmp2_pkg::VALUE_BITS-1:0] total_energy
);
	import hfmp2_pkg::*;

	// A waiting result word holds until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(total_energy))
		else $error("result word changed while stalled");

	// A clear request starts the clearing pass.
	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && op == OP_CLEAR |=> !in_ready)
		else $error("input accepted during clearing pass");

	// A compute request closes the input side once it is accepted.
	a_compute_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && op == OP_COMPUTE |=> !in_ready)
		else $error("input accepted during compute");

	// An integral load closes the input side once accepted, as its eight writes begin.
	a_integral_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && op == OP_INTEGRAL |=> !in_ready ##1 !in_ready)
		else $error("input accepted during integral writes");
endmodule

bind hf_mp2_energy_accumulator hfmp2_checker u_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready), .op(op),
	.out_valid(out_valid), .out_ready(out_ready), .total_energy(total_energy)
);
